/* design/ptrs_pkg.sv */
// Shared types and constants for the per-target retry scheduler.
// No dependencies; imported by ptrs_ctrl, ptrs_dp and the top level.
package ptrs_pkg;

  localparam int MASK_W = 8;
  localparam logic [7:0] ATT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_RESULT   = 2'd1,
    CMD_NEW_PLAY = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    PH_WAITING   = 2'd0,
    PH_INFLIGHT  = 2'd1,
    PH_DONE      = 2'd2,
    PH_ABANDONED = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_TARGETS       = 3'd0,
    REG_REFRESH       = 3'd1,
    REG_ANN_DELAY     = 3'd2,
    REG_SUB_DELAY     = 3'd3,
    REG_ANN_LIMIT     = 3'd4,
    REG_MIN_LENGTH    = 3'd5,
    REG_PLAY_CAP      = 3'd6,
    REG_SPARE         = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PRIME,
    ST_WALK,
    ST_FLUSH,
    ST_RES_RD,
    ST_RES_WR
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        playing;
    logic [31:0] track_length_ms;
    logic [31:0] track_position_ms;
    logic [7:0]  authed_mask;
    logic [2:0]  slot_target;
    logic        slot_kind;
    logic        accepted;
    logic [7:0]  result_play;
  } in_item_t;

  typedef struct packed {
    logic [2:0] issue_target;
    logic       issue_kind;
    logic [7:0] issue_play;
    logic [7:0] issue_attempt;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic bump_play;
    logic idx_clr;
    logic clr_wr;
    logic prime;
    logic walk_eval;
    logic flush;
    logic res_rd;
    logic res_wr;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_last;
    logic no_targets;
    logic res_ok;
  } ctl_sts_t;

endpackage

/* design/ptrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptrs_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ptrs_ctrl.sv */
// Sequencer for the retry scheduler: clear sweep, tick walk, result update.
// Depends on ptrs_pkg; drives the datapath through ctl_cmd_t.
module ptrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_command,
  input  ptrs_pkg::ctl_sts_t  sts,
  output ptrs_pkg::ctl_cmd_t  cmd,
  output logic                busy
);
  import ptrs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (cmd_e_t'(in_command))
            CMD_NEW_PLAY: state_nxt = ST_CLEAR;
            CMD_TICK:     state_nxt = sts.no_targets ? ST_IDLE : ST_PRIME;
            CMD_RESULT:   state_nxt = ST_RES_RD;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:  state_nxt = sts.clr_last ? ST_IDLE : ST_CLEAR;
      ST_PRIME:  state_nxt = ST_WALK;
      ST_WALK:   state_nxt = sts.walk_last ? ST_FLUSH : ST_WALK;
      ST_FLUSH:  state_nxt = ST_IDLE;
      ST_RES_RD: state_nxt = sts.res_ok ? ST_RES_WR : ST_IDLE;
      ST_RES_WR: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (cmd_e_t'(in_command))
            CMD_NEW_PLAY: begin
              cmd.bump_play = 1'b1;
              cmd.idx_clr   = 1'b1;
            end
            CMD_TICK: cmd.idx_clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CLEAR:  cmd.clr_wr    = 1'b1;
      ST_PRIME:  cmd.prime     = 1'b1;
      ST_WALK:   cmd.walk_eval = 1'b1;
      ST_FLUSH:  cmd.flush     = 1'b1;
      ST_RES_RD: cmd.res_rd    = sts.res_ok;
      ST_RES_WR: cmd.res_wr    = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef ASSERT_OFF
  a_walk_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && !sts.walk_last) |=> (state_r == ST_WALK))
    else $error("tick walk ended early");
  a_new_play_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_NEW_PLAY) |=> (state_r == ST_CLEAR))
    else $error("new play did not start clear sweep");
`endif

endmodule

/* design/ptrs_dp.sv */
// Datapath: config registers, latched item, slot RAM, slot update and result staging.
// Depends on ptrs_pkg and ptrs_ram.
module ptrs_dp #(
  parameter int MAX_TARGETS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptrs_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  ptrs_pkg::ctl_cmd_t  cmd,
  output ptrs_pkg::ctl_sts_t  sts,
  output logic                out_valid,
  output ptrs_pkg::out_item_t out_item
);
  import ptrs_pkg::*;

  localparam int SLOTS = 2 * MAX_TARGETS;
  localparam int SW    = $clog2(SLOTS);
  localparam int VIS   = (MAX_TARGETS < MASK_W) ? MAX_TARGETS : MASK_W;
  localparam int EW    = (SW > 4) ? SW + 1 : 5;
  localparam int W     = 2 + TIME_BITS + 8;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // config
  logic [3:0]           tiu_r;
  logic [TIME_BITS-1:0] refresh_r, ann_delay_r, sub_delay_r;
  logic [31:0]          min_len_r, cap_r;
  logic [7:0]           ann_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiu_r       <= 4'd0;
      refresh_r   <= TIME_BITS'(32'd300000);
      ann_delay_r <= TIME_BITS'(32'd5000);
      sub_delay_r <= TIME_BITS'(32'd30000);
      ann_limit_r <= 8'd3;
      min_len_r   <= 32'd30000;
      cap_r       <= 32'd240000;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGETS:    tiu_r       <= cfg_wdata[3:0];
        REG_REFRESH:    refresh_r   <= TIME_BITS'(cfg_wdata);
        REG_ANN_DELAY:  ann_delay_r <= TIME_BITS'(cfg_wdata);
        REG_SUB_DELAY:  sub_delay_r <= TIME_BITS'(cfg_wdata);
        REG_ANN_LIMIT:  ann_limit_r <= cfg_wdata[7:0];
        REG_MIN_LENGTH: min_len_r   <= cfg_wdata;
        REG_PLAY_CAP:   cap_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // length and position stay 32 bits wide: they are never compared with slot times
  logic [31:0] min_len32, cap32;
  assign min_len32 = min_len_r;
  assign cap32     = cap_r;

  logic [3:0] nt;
  assign nt = (tiu_r > 4'(VIS)) ? 4'(VIS) : tiu_r;

  // latched item
  logic [TIME_BITS-1:0] now_r;
  logic                 playing_r, kind_r, acc_r, ready_r;
  logic [31:0]          len_r, pos_r;
  logic [7:0]           authed_r, rplay_r, play_r;
  logic [2:0]           tgt_r;
  logic [SW-1:0]        idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      play_r <= 8'd0;
      idx_r  <= '0;
    end else begin
      if (cmd.load) begin
        now_r <= TIME_BITS'(in_item.now_ms);
      end
      if (cmd.bump_play) begin
        play_r <= play_r + 8'd1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.clr_wr || cmd.walk_eval) begin
        idx_r <= idx_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      playing_r <= in_item.playing;
      len_r     <= in_item.track_length_ms;
      pos_r     <= in_item.track_position_ms;
      authed_r  <= in_item.authed_mask;
      tgt_r     <= in_item.slot_target;
      kind_r    <= in_item.slot_kind;
      acc_r     <= in_item.accepted;
      rplay_r   <= in_item.result_play;
    end
  end

  logic [31:0] half, hcap;
  assign half = len_r >> 1;
  assign hcap = (half > cap32) ? cap32 : half;

  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      ready_r <= (len_r > min_len32) && (pos_r >= hcap);
    end
  end

  // slot RAM
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr, res_slot;
  logic [W-1:0]  ram_wdata, ram_rdata;

  ptrs_ram #(.WIDTH(W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  phase_t               rd_ph;
  logic [TIME_BITS-1:0] rd_due;
  logic [7:0]           rd_att;
  assign rd_ph  = phase_t'(ram_rdata[W-1 -: 2]);
  assign rd_due = ram_rdata[8 +: TIME_BITS];
  assign rd_att = ram_rdata[7:0];

  assign res_slot = SW'({tgt_r, kind_r});

  // saturating due-time add
  logic [TIME_BITS-1:0] delay;
  logic [TIME_BITS:0]   due_sum;
  logic [TIME_BITS-1:0] due_new;
  always_comb begin
    if (acc_r) begin
      delay = refresh_r;
    end else if (kind_r) begin
      delay = sub_delay_r;
    end else begin
      delay = ann_delay_r;
    end
  end
  assign due_sum = {1'b0, now_r} + {1'b0, delay};
  assign due_new = due_sum[TIME_BITS] ? TMAX : due_sum[TIME_BITS-1:0];

  // walk evaluation of slot idx_r
  logic       ge, kind_w, au, rearm, issue;
  logic [2:0] t3;
  phase_t     ph1, ph2;
  logic [7:0] att1, att2;

  assign ge     = (now_r >= rd_due);
  assign kind_w = idx_r[0];
  assign t3     = 3'(idx_r >> 1);
  assign au     = authed_r[t3];
  assign rearm  = !kind_w && (rd_ph == PH_DONE) && playing_r && ge;
  assign ph1    = rearm ? PH_WAITING : rd_ph;
  assign att1   = rearm ? 8'd0 : rd_att;
  assign issue  = au && (ph1 == PH_WAITING) && ge && (kind_w ? ready_r : playing_r);
  assign att2   = issue ? ((att1 == ATT_MAX) ? ATT_MAX : att1 + 8'd1) : att1;
  assign ph2    = issue ? PH_INFLIGHT : ph1;

  // result update
  phase_t               res_ph;
  logic [TIME_BITS-1:0] res_due;
  always_comb begin
    res_ph  = PH_WAITING;
    res_due = due_new;
    if (acc_r) begin
      res_ph  = PH_DONE;
      res_due = kind_r ? rd_due : due_new;
    end else if (!kind_r && (rd_att >= ann_limit_r)) begin
      res_ph  = PH_ABANDONED;
      res_due = rd_due;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {PH_WAITING, now_r, 8'd0};
    ram_raddr = idx_r;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.walk_eval) begin
      ram_we    = au;
      ram_wdata = {ph2, rd_due, att2};
      ram_raddr = idx_r + SW'(1);
    end else if (cmd.res_rd) begin
      ram_raddr = res_slot;
    end else if (cmd.res_wr) begin
      ram_we    = 1'b1;
      ram_waddr = res_slot;
      ram_wdata = {res_ph, res_due, rd_att};
    end
  end

  // status
  assign sts.clr_last   = (idx_r == SW'(SLOTS - 1));
  assign sts.walk_last  = (EW'(idx_r) == (EW'({nt, 1'b0}) - EW'(1)));
  assign sts.no_targets = (nt == 4'd0);
  assign sts.res_ok     = (rplay_r == play_r) && ({1'b0, tgt_r} < nt);

  // one result held back so the final one of a tick can carry last
  logic      pend_v_r, out_valid_r;
  out_item_t pend_r, out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.walk_eval && issue) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b1;
      end else if (cmd.flush) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_eval && issue) begin
      pend_r     <= '{issue_target: t3, issue_kind: kind_w, issue_play: play_r,
                      issue_attempt: att2, last: 1'b0};
      out_item_r <= pend_r;
    end else if (cmd.flush) begin
      out_item_r <= '{issue_target: pend_r.issue_target, issue_kind: pend_r.issue_kind,
                      issue_play: pend_r.issue_play,
                      issue_attempt: pend_r.issue_attempt, last: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last) |-> !pend_v_r)
    else $error("final item left a pending item behind");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(cmd.walk_eval) || $past(cmd.flush)))
    else $error("item strobed outside a tick");
`endif

endmodule

/* design/per_target_retry_scheduler.sv */
// Top level of the per-target retry scheduler.
// Depends on ptrs_pkg, ptrs_ctrl and ptrs_dp (which holds ptrs_ram).
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------
//   input   | start / busy         | in_item  (in_item_t)
//   result  | out_valid strobe     | out_item (out_item_t)
//   config  | cfg_we               | cfg_index, cfg_wdata
//
// A tick visits one RAM slot per cycle over the 2*N slots of the N targets in use,
// after a RAM read setup and before a final result flush; a result item reads its
// slot and writes it back only for the current play and a target in use; a new play
// clears the slot RAM in a sweep. After reset the same sweep runs with busy high.
// Results are strobed for one cycle each; the receiver cannot stall them.
module per_target_retry_scheduler #(
  parameter int MAX_TARGETS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptrs_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ptrs_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import ptrs_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ptrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_item.command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  ptrs_dp #(.MAX_TARGETS(MAX_TARGETS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* tb/per_target_retry_scheduler_tb.sv */
// Self-checking testbench for per_target_retry_scheduler: random and directed items
// are checked against a behavioral model of the slot scheduler.
// Depends on ptrs_pkg and the per_target_retry_scheduler RTL.
module per_target_retry_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrs_pkg::*;

  localparam int          SLOTS        = 16;
  localparam int          VISIT_MAX    = 8;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;
  localparam logic        KIND_ANNOUNCE = 1'b0;
  localparam logic        KIND_SUBMIT   = 1'b1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_TARGETS;
  logic [31:0] cfg_wdata = '0;

  per_target_retry_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scheduler model state and registers
  phase_t      slot_ph  [SLOTS];
  logic [31:0] slot_due [SLOTS];
  logic [7:0]  slot_att [SLOTS];
  logic [7:0]  play_no;
  logic [3:0]  m_targets;
  logic [31:0] m_refresh, m_ann_delay, m_sub_delay, m_min_len, m_cap;
  logic [7:0]  m_ann_limit;

  in_item_t    pending_cmds[$];
  out_item_t   expected_issues[$];
  int          n_sent = 0;
  int          n_taken = 0;
  int          n_errors = 0;
  int unsigned n_cycles = 0;
  bit          idle_on = 1'b1;
  int          gap_cnt = 0;

  // stimulus generator view
  logic [31:0] gen_now = '0;
  logic [31:0] gen_len = '0;
  logic [31:0] gen_pos = '0;
  logic [7:0]  gen_play = '0;

  function automatic logic [31:0] due_after(logic [31:0] now_v, logic [31:0] delay);
    logic [32:0] sum;
    sum = {1'b0, now_v} + {1'b0, delay};
    return sum[32] ? TIME_MAX : sum[31:0];
  endfunction

  function automatic logic submit_ready(logic [31:0] len_v, logic [31:0] pos_v);
    logic [31:0] half;
    if (len_v <= m_min_len) return 1'b0;
    half = len_v >> 1;
    if (half > m_cap) half = m_cap;
    return pos_v >= half;
  endfunction

  task automatic clear_slots(logic [31:0] now_v);
    for (int i = 0; i < SLOTS; i++) begin
      slot_ph[i]  = PH_WAITING;
      slot_due[i] = now_v;
      slot_att[i] = '0;
    end
  endtask

  task automatic predict_issues(in_item_t it);
    int        n_vis;
    int        s;
    int        cnt;
    logic      ready;
    out_item_t batch [SLOTS];
    n_vis = (m_targets > VISIT_MAX) ? VISIT_MAX : m_targets;
    cnt = 0;
    case (it.command)
      CMD_NEW_PLAY: begin
        play_no = play_no + 8'd1;
        clear_slots(it.now_ms);
      end
      CMD_RESULT: begin
        if (it.result_play == play_no && it.slot_target < n_vis) begin
          s = it.slot_target * 2 + it.slot_kind;
          if (it.accepted) begin
            slot_ph[s] = PH_DONE;
            if (it.slot_kind == KIND_ANNOUNCE) slot_due[s] = due_after(it.now_ms, m_refresh);
          end else if (it.slot_kind == KIND_ANNOUNCE && slot_att[s] >= m_ann_limit) begin
            slot_ph[s] = PH_ABANDONED;
          end else begin
            slot_ph[s]  = PH_WAITING;
            slot_due[s] = due_after(it.now_ms,
                (it.slot_kind == KIND_ANNOUNCE) ? m_ann_delay : m_sub_delay);
          end
        end
      end
      CMD_TICK: begin
        ready = submit_ready(it.track_length_ms, it.track_position_ms);
        for (int t = 0; t < n_vis; t++) begin
          if (it.authed_mask[t]) begin
            for (int k = 0; k < 2; k++) begin
              s = t * 2 + k;
              if (k == KIND_ANNOUNCE && slot_ph[s] == PH_DONE && it.playing &&
                  it.now_ms >= slot_due[s]) begin
                slot_ph[s]  = PH_WAITING;
                slot_att[s] = '0;
              end
              if (slot_ph[s] == PH_WAITING && it.now_ms >= slot_due[s] &&
                  ((k == KIND_SUBMIT) ? ready : it.playing)) begin
                slot_ph[s] = PH_INFLIGHT;
                if (slot_att[s] != ATT_MAX) slot_att[s] = slot_att[s] + 8'd1;
                batch[cnt].issue_target  = t[2:0];
                batch[cnt].issue_kind    = k[0];
                batch[cnt].issue_play    = play_no;
                batch[cnt].issue_attempt = slot_att[s];
                batch[cnt].last          = 1'b0;
                cnt++;
              end
            end
          end
        end
        if (cnt > 0) batch[cnt - 1].last = 1'b1;
        for (int i = 0; i < cnt; i++) expected_issues = {expected_issues, batch[i]};
      end
      default: ;
    endcase
  endtask

  function automatic string fmt_issue(out_item_t o);
    return $sformatf("target %0d kind %0d play %0d attempt %0d last %0d",
                     o.issue_target, o.issue_kind, o.issue_play, o.issue_attempt, o.last);
  endfunction

  function automatic int draw_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin : drv
    int gap;
    if (!rst_n) begin
      start   <= 1'b0;
      gap_cnt <= 0;
    end else if (start && !busy) begin
      gap = draw_gap();
      if (gap == 0 && pending_cmds.size() != 0) begin
        in_item <= pending_cmds.pop_front();
      end else begin
        start   <= 1'b0;
        gap_cnt <= gap;
      end
    end else if (!start) begin
      if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (pending_cmds.size() != 0) begin
        in_item <= pending_cmds.pop_front();
        start   <= 1'b1;
      end
    end
  end

  // monitor: predict on acceptance, compare each strobed issue item
  always @(posedge clk) begin : mon
    out_item_t exp_i;
    if (rst_n) begin
      if (start && !busy) begin
        predict_issues(in_item);
        n_taken++;
      end
      if (out_valid) begin
        if (expected_issues.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %s", $time,
                   fmt_issue(out_item));
          n_errors++;
        end else begin
          exp_i = expected_issues.pop_front();
          if (out_item !== exp_i) begin
            $display("%0t: expected %s, actual %s", $time, fmt_issue(exp_i),
                     fmt_issue(out_item));
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("per_target_retry_scheduler: mismatch");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TARGETS:    m_targets   = val[3:0];
      REG_REFRESH:    m_refresh   = val;
      REG_ANN_DELAY:  m_ann_delay = val;
      REG_SUB_DELAY:  m_sub_delay = val;
      REG_ANN_LIMIT:  m_ann_limit = val[7:0];
      REG_MIN_LENGTH: m_min_len   = val;
      REG_PLAY_CAP:   m_cap       = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [3:0] tgt, logic [31:0] refr, logic [31:0] ann,
                           logic [31:0] sub, logic [7:0] lim, logic [31:0] minl,
                           logic [31:0] cap);
    write_reg(REG_TARGETS, {28'd0, tgt});
    write_reg(REG_REFRESH, refr);
    write_reg(REG_ANN_DELAY, ann);
    write_reg(REG_SUB_DELAY, sub);
    write_reg(REG_ANN_LIMIT, {24'd0, lim});
    write_reg(REG_MIN_LENGTH, minl);
    write_reg(REG_PLAY_CAP, cap);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    int waited;
    while (n_taken != n_sent) @(posedge clk);
    waited = 0;
    while (expected_issues.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    if (expected_issues.size() != 0) begin
      $display("%0t: %0d expected items never arrived, next %s", $time,
               expected_issues.size(), fmt_issue(expected_issues[0]));
      n_errors += expected_issues.size();
      expected_issues.delete();
    end
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.command           = 2'($urandom_range(0, 3));
    it.now_ms            = $urandom;
    it.playing           = 1'($urandom_range(0, 1));
    it.track_length_ms   = $urandom;
    it.track_position_ms = $urandom;
    it.authed_mask       = 8'($urandom_range(0, 255));
    it.slot_target       = 3'($urandom_range(0, 7));
    it.slot_kind         = 1'($urandom_range(0, 1));
    it.accepted          = 1'($urandom_range(0, 1));
    it.result_play       = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send(in_item_t it);
    pending_cmds = {pending_cmds, it};
    n_sent++;
  endtask

  task automatic send_tick(logic [31:0] now_v, logic play_v, logic [31:0] len_v,
                           logic [31:0] pos_v, logic [7:0] auth_v);
    in_item_t it;
    it = rand_item();
    it.command           = CMD_TICK;
    it.now_ms            = now_v;
    it.playing           = play_v;
    it.track_length_ms   = len_v;
    it.track_position_ms = pos_v;
    it.authed_mask       = auth_v;
    send(it);
  endtask

  task automatic send_result(logic [31:0] now_v, logic [2:0] tgt, logic kind,
                             logic acc, logic [7:0] rplay);
    in_item_t it;
    it = rand_item();
    it.command     = CMD_RESULT;
    it.now_ms      = now_v;
    it.slot_target = tgt;
    it.slot_kind   = kind;
    it.accepted    = acc;
    it.result_play = rplay;
    send(it);
  endtask

  task automatic send_new_play(logic [31:0] now_v, int unsigned len_max);
    in_item_t it;
    it = rand_item();
    it.command = CMD_NEW_PLAY;
    it.now_ms  = now_v;
    gen_play   = gen_play + 8'd1;
    gen_len    = $urandom_range(0, len_max);
    gen_pos    = '0;
    send(it);
  endtask

  // mostly well-formed play sessions with some noise and stale results
  task automatic gen_phase(int n, int unsigned ntgt, int unsigned step_max,
                           int unsigned len_max);
    int          r;
    logic [2:0]  tgt;
    logic [7:0]  rplay;
    logic [7:0]  auth;
    send_new_play(gen_now, len_max);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send(rand_item());
      end else if (r < 18) begin
        send_new_play(gen_now, len_max);
      end else if (r < 60) begin
        gen_now = gen_now + $urandom_range(0, step_max);
        gen_pos = gen_pos + $urandom_range(0, len_max / 4 + 1);
        auth = ($urandom_range(0, 9) < 7) ? 8'hFF : 8'($urandom_range(0, 255));
        send_tick(gen_now, $urandom_range(0, 9) != 0, gen_len, gen_pos, auth);
      end else begin
        if (ntgt > 0 && $urandom_range(0, 9) < 8) tgt = 3'($urandom_range(0, ntgt - 1));
        else tgt = 3'($urandom_range(0, 7));
        rplay = ($urandom_range(0, 9) != 0) ? gen_play : 8'($urandom_range(0, 255));
        send_result(gen_now, tgt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    rplay);
      end
    end
  endtask

  initial begin
    clear_slots('0);
    play_no     = '0;
    m_targets   = 4'd0;
    m_refresh   = 32'd300000;
    m_ann_delay = 32'd5000;
    m_sub_delay = 32'd30000;
    m_ann_limit = 8'd3;
    m_min_len   = 32'd30000;
    m_cap       = 32'd240000;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: retry, refresh, abandon, pause, stale and ignored results, saturation
    idle_on = 1'b1;
    configure(4'd2, 32'd30, 32'd10, 32'd20, 8'd2, 32'd100, 32'd50);
    send_new_play(32'd0, 200);
    send_tick(32'd0, 1'b1, 32'd200, 32'd100, 8'hFF);
    send_result(32'd2, 3'd0, KIND_ANNOUNCE, 1'b1, gen_play);
    send_result(32'd2, 3'd1, KIND_ANNOUNCE, 1'b0, gen_play);
    send_result(32'd3, 3'd0, KIND_SUBMIT, 1'b0, gen_play);
    send_result(32'd3, 3'd1, KIND_SUBMIT, 1'b1, gen_play);
    send_tick(32'd5, 1'b1, 32'd200, 32'd100, 8'hFF);
    send_tick(32'd15, 1'b1, 32'd200, 32'd100, 8'hFF);
    send_result(32'd16, 3'd1, KIND_ANNOUNCE, 1'b0, gen_play);
    send_tick(32'd40, 1'b1, 32'd200, 32'd100, 8'hFF);
    send_tick(32'd60, 1'b0, 32'd200, 32'd100, 8'hFF);
    send_result(32'd60, 3'd0, KIND_SUBMIT, 1'b0, gen_play - 8'd1);
    send_result(32'd60, 3'd5, KIND_SUBMIT, 1'b0, gen_play);
    begin : unknown_cmd
      in_item_t it;
      it = rand_item();
      it.command = CMD_NONE;
      send(it);
    end
    send_tick(32'd61, 1'b1, 32'd200, 32'd100, 8'h00);
    send_result(32'd61, 3'd0, KIND_SUBMIT, 1'b0, gen_play);
    send_tick(32'd100, 1'b1, 32'd100, 32'd100, 8'hFF);
    send_tick(32'd100, 1'b1, TIME_MAX, TIME_MAX, 8'hFF);
    send_result(32'hFFFF_FFF0, 3'd0, KIND_ANNOUNCE, 1'b1, gen_play);
    send_tick(32'hFFFF_FFFE, 1'b1, 32'd200, 32'd0, 8'hFF);
    send_tick(TIME_MAX, 1'b1, 32'd200, 32'd0, 8'hFF);
    send_new_play(TIME_MAX, 200);
    send_tick(TIME_MAX, 1'b1, 32'd200, 32'd100, 8'h02);
    send_result(TIME_MAX, 3'd7, KIND_SUBMIT, 1'b1, gen_play);
    wait_quiet();

    gen_now = '0;
    idle_on = 1'b1;
    configure(4'd8, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0);
    gen_phase(14, 8, 5, 1000);
    wait_quiet();

    idle_on = 1'b0;
    configure(4'd15, TIME_MAX, TIME_MAX, TIME_MAX, 8'hFF, TIME_MAX, TIME_MAX);
    gen_phase(14, 8, 32'h4000_0000, 32'hFFFF_FFFF);
    wait_quiet();

    idle_on = 1'b1;
    configure(4'd3, 32'd40, 32'd10, 32'd25, 8'd1, 32'd500, 32'd300);
    gen_phase(14, 3, 30, 1200);
    wait_quiet();

    idle_on = 1'b0;
    configure(4'd0, 32'd30, 32'd10, 32'd20, 8'd3, 32'd100, 32'd50);
    gen_phase(10, 0, 20, 400);
    wait_quiet();

    idle_on = 1'b1;
    begin : rand_setting
      logic [3:0] tgt;
      tgt = 4'($urandom_range(1, 8));
      configure(tgt, $urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(0, 60),
                8'($urandom_range(0, 4)), $urandom_range(0, 800), $urandom_range(0, 600));
      gen_phase(16, tgt, 40, 2000);
    end
    wait_quiet();

    // attempt counters climb while retries keep being rejected
    idle_on = 1'b0;
    configure(4'd1, 32'd0, 32'd0, 32'd0, 8'hFF, 32'd0, 32'd0);
    send_new_play(gen_now, 100);
    for (int i = 0; i < 4; i++) begin
      send_tick(gen_now, 1'b1, 32'd10, 32'd10, 8'hFF);
      send_result(gen_now, 3'd0, KIND_ANNOUNCE, 1'b0, gen_play);
      send_result(gen_now, 3'd0, KIND_SUBMIT, 1'b0, gen_play);
    end
    wait_quiet();

    idle_on = 1'b1;
    configure(4'd8, 32'd300000, 32'd5000, 32'd30000, 8'd3, 32'd30000, 32'd240000);
    gen_phase(12, 8, 20000, 600000);
    wait_quiet();

    if (n_errors == 0) begin
      $display("per_target_retry_scheduler: match");
    end else begin
      $display("per_target_retry_scheduler: mismatch");
    end
    $finish;
  end

endmodule
